### sv/kwm_pkg.sv
// Shared types and helpers for the k-way sorted merge core.
// No dependencies; imported by the cell, the chain and the top level.
package kwm_pkg;

  // one stored entry: element value and the stream it came from
  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         src;
  } kwm_entry_t;

  // per-cycle command broadcast along the chain
  typedef struct packed {
    logic push;
    logic pop;
  } kwm_ctl_t;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } kwm_state_t;

  // true when entry a orders strictly ahead of entry b
  function automatic logic kwm_before(input kwm_entry_t a, input kwm_entry_t b);
    logic res;
    if (a.value != b.value) begin
      res = (a.value < b.value);
    end else begin
      res = (a.src < b.src);
    end
    return res;
  endfunction

endpackage

### sv/kwm_cell.sv
// One slot of the sorted store: holds a single entry.
// Depends on kwm_pkg. Inserts from its left neighbor, shifts in from its right.
module kwm_cell
  import kwm_pkg::*;
(
  input  logic       clk,
  input  kwm_ctl_t   ctl,
  input  logic       occ,       // slot currently holds a live entry
  input  kwm_entry_t ins,       // entry being pushed, broadcast to all slots
  input  kwm_entry_t left_ent,  // neighbor toward the head
  input  logic       left_lt,   // new entry orders ahead of the left neighbor
  input  kwm_entry_t right_ent, // neighbor toward the tail
  output kwm_entry_t ent,
  output logic       lt
);

  kwm_entry_t ent_r;
  kwm_entry_t ent_nxt;

  // empty slots count as larger than anything
  assign lt  = !occ || kwm_before(ins, ent_r);
  assign ent = ent_r;

  // pop shifts toward the head; push opens a gap where the new entry lands
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.pop) begin
      ent_nxt = right_ent;
    end else if (ctl.push && lt) begin
      ent_nxt = left_lt ? left_ent : ins;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

### sv/kwm_chain.sv
// Row of kwm_cell slots kept in ascending order, head at slot 0.
// Depends on kwm_pkg and kwm_cell. Occupancy follows from the fill count.
module kwm_chain
  import kwm_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int SW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  kwm_ctl_t      ctl,
  input  logic [SW-1:0] size,
  input  kwm_entry_t    ins,
  output kwm_entry_t    head
);

  kwm_entry_t ent_w [DEPTH];
  logic       lt_w  [DEPTH];
  logic       occ_w [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      kwm_entry_t left_e;
      logic       left_l;
      kwm_entry_t right_e;

      assign occ_w[g] = (int'(size) > g);

      if (g == 0) begin : g_first
        assign left_e = ins;
        assign left_l = 1'b0;
      end else begin : g_mid
        assign left_e = ent_w[g-1];
        assign left_l = lt_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign right_e = ent_w[g];
      end else begin : g_body
        assign right_e = ent_w[g+1];
      end

      kwm_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ_w[g]),
        .ins       (ins),
        .left_ent  (left_e),
        .left_lt   (left_l),
        .right_ent (right_e),
        .ent       (ent_w[g]),
        .lt        (lt_w[g])
      );
    end
  endgenerate

  assign head = ent_w[0];

endmodule

### sv/k_way_sorted_merge_core.sv
// K-way sorted merge: one item in, smallest stored entry out.
// Sequencing: a push is taken in the accept cycle, the pop runs in the next cycle and
// the result strobes in the cycle after; busy is high for that one pop cycle, and no
// new item is accepted while busy. Items without a result (load heads, ignored items)
// never raise busy; the all-empty marker strobes the cycle after its accept. Synchronous
// active-low reset empties the store and returns to load phase; stream count resets to 8.
// Results cannot be stalled.
module k_way_sorted_merge_core
  import kwm_pkg::*;
#(
  parameter int MAX_LISTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_list_index,
  input  logic signed [31:0] in_value,
  input  logic               in_present,
  output logic               out_strobe,
  output logic signed [31:0] out_value_res,
  output logic [2:0]         out_source_list,
  output logic               out_last,
  output logic               out_none
);

  localparam int SW = $clog2(MAX_LISTS + 1);

  kwm_state_t         state_r, state_nxt;
  logic [3:0]         list_count_r, list_count_nxt;
  logic [3:0]         heads_r, heads_nxt;
  logic [SW-1:0]      size_r, size_nxt;
  logic               merging_r, merging_nxt;
  logic               strobe_r, strobe_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [2:0]         osrc_r, osrc_nxt;
  logic               olast_r, olast_nxt;
  logic               onone_r, onone_nxt;

  logic [3:0]    count;
  logic          accept, valid_src, full, do_push;
  logic [SW-1:0] size_after;
  logic [3:0]    heads_inc;
  kwm_ctl_t      ctl;
  kwm_entry_t    ins, head;

  // clamp the stream count into 1..MAX_LISTS
  always_comb begin
    if (list_count_r == 4'd0) begin
      count = 4'd1;
    end else if (int'(list_count_r) > MAX_LISTS) begin
      count = 4'(MAX_LISTS);
    end else begin
      count = list_count_r;
    end
  end

  assign busy       = (state_r == ST_POP);
  assign accept     = start && !busy;
  assign valid_src  = ({1'b0, in_list_index} < count);
  assign full       = (size_r == SW'(MAX_LISTS));
  assign do_push    = accept && valid_src && in_present && !full;
  assign size_after = size_r + SW'(do_push);
  assign heads_inc  = heads_r + 4'd1;

  assign ins.value = in_value;
  assign ins.src   = in_list_index;

  // sequencer: push on accept, pop in the following cycle
  always_comb begin
    state_nxt      = state_r;
    list_count_nxt = cfg_we ? cfg_wdata : list_count_r;
    heads_nxt      = heads_r;
    size_nxt       = size_r;
    merging_nxt    = merging_r;
    strobe_nxt     = 1'b0;
    oval_nxt       = oval_r;
    osrc_nxt       = osrc_r;
    olast_nxt      = olast_r;
    onone_nxt      = onone_r;
    ctl.push       = do_push;
    ctl.pop        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && valid_src) begin
          size_nxt = size_after;
          if (!merging_r) begin
            heads_nxt = heads_inc;
            if (heads_inc >= count) begin
              if (size_after == '0) begin
                // every stream empty: marker result, stay in load
                heads_nxt  = 4'd0;
                strobe_nxt = 1'b1;
                oval_nxt   = 32'sd0;
                osrc_nxt   = 3'd0;
                olast_nxt  = 1'b1;
                onone_nxt  = 1'b1;
              end else begin
                merging_nxt = 1'b1;
                state_nxt   = ST_POP;
              end
            end
          end else if (size_after == '0) begin
            merging_nxt = 1'b0;
            heads_nxt   = 4'd0;
          end else begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        ctl.pop    = 1'b1;
        size_nxt   = size_r - SW'(1);
        strobe_nxt = 1'b1;
        oval_nxt   = head.value;
        osrc_nxt   = head.src;
        onone_nxt  = 1'b0;
        olast_nxt  = (size_r == SW'(1));
        if (size_r == SW'(1)) begin
          merging_nxt = 1'b0;
          heads_nxt   = 4'd0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      list_count_r <= 4'd8;
      heads_r      <= 4'd0;
      size_r       <= '0;
      merging_r    <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      list_count_r <= list_count_nxt;
      heads_r      <= heads_nxt;
      size_r       <= size_nxt;
      merging_r    <= merging_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    oval_r  <= oval_nxt;
    osrc_r  <= osrc_nxt;
    olast_r <= olast_nxt;
    onone_r <= onone_nxt;
  end

  kwm_chain #(
    .DEPTH (MAX_LISTS),
    .SW    (SW)
  ) u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .size (size_r),
    .ins  (ins),
    .head (head)
  );

  assign out_strobe      = strobe_r;
  assign out_value_res   = oval_r;
  assign out_source_list = osrc_r;
  assign out_last        = olast_r;
  assign out_none        = onone_r;

endmodule

### sv/kwm_checker.sv
// Port-level checks for k_way_sorted_merge_core, attached with bind below.
// Depends only on the top level's ports.
module kwm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic               out_last,
  input logic               out_none
);

  // a pop occupies exactly one cycle
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // every pop delivers a real element next cycle
  a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !out_none))
    else $error("pop did not deliver an element");

  // the empty marker follows directly from an accepted transfer and ends the stream
  a_none_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_none) |-> ($past(start && !busy) && out_last))
    else $error("empty marker without a preceding transfer");

  // results come only from a transfer or a pop in the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start && !busy) || $past(busy)))
    else $error("result without cause");

endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_last   (out_last),
  .out_none   (out_none)
);
